// ===== rtl/core/cmt_pkg.sv =====
`timescale 1ns / 1ps

package cmt_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS    = 14;
    localparam int OUT_W        = 16;
    localparam int IDX_W        = 8;
    localparam int CNT_W        = 9;
    localparam int RAD_W        = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_RINGS    = 256;
    localparam int MAX_WEDGES   = 256;

    // Angle and rotation datapath.
    localparam int PHASE_BITS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 33;
    localparam int ZW           = 32;
    localparam int TRIG_W       = 32;
    localparam logic signed [CORDIC_W-1:0] ROT_GAIN = 33'sd652032874;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEDGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd2;

    typedef enum logic [1:0] {
        FACE_TOP    = 2'd0,
        FACE_BOTTOM = 2'd1,
        FACE_SIDE   = 2'd2
    } face_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ROT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_MUL,
        B_DIV,
        B_EMIT
    } back_state_t;

    // One tile job: sine and cosine of both wedge edges plus the ring.
    typedef struct packed {
        logic signed [TRIG_W-1:0] ca;
        logic signed [TRIG_W-1:0] sa;
        logic signed [TRIG_W-1:0] cb;
        logic signed [TRIG_W-1:0] sb;
        logic [IDX_W-1:0]         ring;
    } job_t;

    // Arctangent of 2^-k, where 2^32 is one full turn.
    function automatic logic [ZW-1:0] cordic_angle(input logic [4:0] k);
        logic [ZW-1:0] a;
        begin
            case (k)
                5'd0:    a = 32'h20000000;
                5'd1:    a = 32'h12E4051E;
                5'd2:    a = 32'h09FB385B;
                5'd3:    a = 32'h051111D4;
                5'd4:    a = 32'h028B0D43;
                5'd5:    a = 32'h0145D7E1;
                5'd6:    a = 32'h00A2F61E;
                5'd7:    a = 32'h00517C55;
                5'd8:    a = 32'h0028BE53;
                5'd9:    a = 32'h00145F2F;
                5'd10:   a = 32'h000A2F98;
                5'd11:   a = 32'h000517CC;
                5'd12:   a = 32'h00028BE6;
                5'd13:   a = 32'h000145F3;
                5'd14:   a = 32'h0000A2F9;
                5'd15:   a = 32'h0000517C;
                5'd16:   a = 32'h000028BE;
                5'd17:   a = 32'h0000145F;
                5'd18:   a = 32'h00000A2F;
                5'd19:   a = 32'h00000517;
                5'd20:   a = 32'h0000028B;
                5'd21:   a = 32'h00000145;
                5'd22:   a = 32'h000000A2;
                5'd23:   a = 32'h00000051;
                5'd24:   a = 32'h00000028;
                5'd25:   a = 32'h00000014;
                5'd26:   a = 32'h0000000A;
                5'd27:   a = 32'h00000005;
                5'd28:   a = 32'h00000002;
                5'd29:   a = 32'h00000001;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== rtl/core/cmt_front.sv =====
`timescale 1ns / 1ps

module cmt_front
    import cmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [IDX_W-1:0] wedge_index,
    input  logic [IDX_W-1:0] ring_index,
    output logic             full,
    input  logic [CNT_W-1:0] wedges,
    input  logic [CNT_W-1:0] rings,
    output job_t             job,
    output logic             job_push,
    input  logic             job_full
);

    front_state_t state_reg, state_next;
    logic hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0] hold_w_reg, hold_w_next, hold_i_reg, hold_i_next;
    logic [IDX_W-1:0] ring_reg, ring_next;
    logic [CNT_W-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [PHASE_BITS-1:0] pha_reg, pha_next, phb_reg, phb_next;
    logic wrap_reg, wrap_next;
    logic [4:0] step_reg, step_next;
    logic signed [CORDIC_W-1:0] xa_reg, xa_next, ya_reg, ya_next;
    logic signed [CORDIC_W-1:0] xb_reg, xb_next, yb_reg, yb_next;
    logic signed [ZW-1:0] za_reg, za_next, zb_reg, zb_next;
    logic [1:0] qa_reg, qa_next, qb_reg, qb_next;

    logic [CNT_W:0] ra2, rb2, ra_sub, rb_sub, w_ext, w_plus;
    logic bit_a, bit_b;
    logic [PHASE_BITS-1:0] pha_new, phb_new;
    logic signed [CORDIC_W-1:0] dxa, dya, dxb, dyb;
    logic [ZW-1:0] ang;

    // Folds the first-quadrant rotation back into the full turn.
    function automatic logic [2*TRIG_W-1:0] quad_map(
        input logic [1:0] q,
        input logic signed [CORDIC_W-1:0] x,
        input logic signed [CORDIC_W-1:0] y
    );
        logic signed [CORDIC_W-1:0] c, s;
        begin
            case (q)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
        end
    endfunction

    assign full = hold_valid_reg;
    // Job layout: cosine and sine of edge A, then of edge B, then the ring.
    assign job  = {quad_map(qa_reg, xa_reg, ya_reg), quad_map(qb_reg, xb_reg, yb_reg),
                   ring_reg};

    always_comb
    begin
        ra2     = {rem_a_reg, 1'b0};
        rb2     = {rem_b_reg, 1'b0};
        w_ext   = {1'b0, wedges};
        ra_sub  = ra2 - w_ext;
        rb_sub  = rb2 - w_ext;
        bit_a   = ra2 >= w_ext;
        bit_b   = rb2 >= w_ext;
        pha_new = {pha_reg[PHASE_BITS-2:0], bit_a};
        phb_new = wrap_reg ? '0 : {phb_reg[PHASE_BITS-2:0], bit_b};
        w_plus  = {2'b00, hold_w_reg} + 10'd1;
        dxa     = ya_reg >>> step_reg;
        dya     = xa_reg >>> step_reg;
        dxb     = yb_reg >>> step_reg;
        dyb     = xb_reg >>> step_reg;
        ang     = cordic_angle(step_reg);

        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        hold_w_next     = hold_w_reg;
        hold_i_next     = hold_i_reg;
        ring_next       = ring_reg;
        rem_a_next      = rem_a_reg;
        rem_b_next      = rem_b_reg;
        pha_next        = pha_reg;
        phb_next        = phb_reg;
        wrap_next       = wrap_reg;
        step_next       = step_reg;
        xa_next = xa_reg; ya_next = ya_reg; za_next = za_reg; qa_next = qa_reg;
        xb_next = xb_reg; yb_next = yb_reg; zb_next = zb_reg; qb_next = qb_reg;
        job_push        = 1'b0;

        if (push && !hold_valid_reg)
        begin
            hold_valid_next = 1'b1;
            hold_w_next     = wedge_index;
            hold_i_next     = ring_index;
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    hold_valid_next = 1'b0;
                    // Indexes outside the configured counts are dropped here.
                    if ({1'b0, hold_w_reg} < wedges && {1'b0, hold_i_reg} < rings)
                    begin
                        ring_next  = hold_i_reg;
                        rem_a_next = {1'b0, hold_w_reg};
                        rem_b_next = w_plus[CNT_W-1:0];
                        wrap_next  = w_plus == w_ext;
                        pha_next   = '0;
                        phb_next   = '0;
                        step_next  = '0;
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                rem_a_next = bit_a ? ra_sub[CNT_W-1:0] : ra2[CNT_W-1:0];
                rem_b_next = bit_b ? rb_sub[CNT_W-1:0] : rb2[CNT_W-1:0];
                pha_next   = pha_new;
                phb_next   = phb_new;
                step_next  = step_reg + 5'd1;
                if (step_reg == 5'(PHASE_BITS - 1))
                begin
                    step_next  = '0;
                    qa_next    = pha_new[PHASE_BITS-1:PHASE_BITS-2];
                    qb_next    = phb_new[PHASE_BITS-1:PHASE_BITS-2];
                    za_next    = {2'b00, pha_new[PHASE_BITS-3:0]};
                    zb_next    = {2'b00, phb_new[PHASE_BITS-3:0]};
                    xa_next    = ROT_GAIN;
                    xb_next    = ROT_GAIN;
                    ya_next    = '0;
                    yb_next    = '0;
                    state_next = F_ROT;
                end
            end
            F_ROT:
            begin
                if (!za_reg[ZW-1])
                begin
                    xa_next = xa_reg - dxa; ya_next = ya_reg + dya; za_next = za_reg - ang;
                end
                else
                begin
                    xa_next = xa_reg + dxa; ya_next = ya_reg - dya; za_next = za_reg + ang;
                end
                if (!zb_reg[ZW-1])
                begin
                    xb_next = xb_reg - dxb; yb_next = yb_reg + dyb; zb_next = zb_reg - ang;
                end
                else
                begin
                    xb_next = xb_reg + dxb; yb_next = yb_reg - dyb; zb_next = zb_reg + ang;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_w_reg <= hold_w_next;
        hold_i_reg <= hold_i_next;
        ring_reg   <= ring_next;
        rem_a_reg  <= rem_a_next;
        rem_b_reg  <= rem_b_next;
        pha_reg    <= pha_next;
        phb_reg    <= phb_next;
        wrap_reg   <= wrap_next;
        step_reg   <= step_next;
        xa_reg <= xa_next; ya_reg <= ya_next; za_reg <= za_next; qa_reg <= qa_next;
        xb_reg <= xb_next; yb_reg <= yb_next; zb_reg <= zb_next; qb_reg <= qb_next;
    end

endmodule

// ===== rtl/core/cmt_job_queue.sv =====
`timescale 1ns / 1ps

module cmt_job_queue
    import cmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty
);

    job_t slot_reg [2];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/cmt_back.sv =====
`timescale 1ns / 1ps

module cmt_back
    import cmt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  job_t                    job_in,
    input  logic                    job_empty,
    output logic                    job_pop,
    input  logic [CNT_W-1:0]        rings,
    input  logic [RAD_W-1:0]        radius,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] pos_x,
    output logic signed [OUT_W-1:0] pos_y,
    output logic signed [OUT_W-1:0] pos_z,
    output logic signed [OUT_W-1:0] norm_x,
    output logic signed [OUT_W-1:0] norm_y,
    output logic signed [OUT_W-1:0] norm_z,
    output logic [1:0]              face_kind,
    output logic                    last_vertex
);

    localparam int QW        = 25;
    localparam int RKW       = 23;
    localparam int PW        = TRIG_W + RKW + 1;
    localparam int MW        = PW - 1;
    localparam int SH        = 30;
    localparam int MUL_COUNT = 12;
    localparam int DIV_STEPS = QW;
    localparam int HW        = CNT_W + FRAC_BITS;
    localparam int DW        = CNT_W + 2;
    localparam logic signed [OUT_W-1:0] ONE  = OUT_W'(1 << FRAC_BITS);
    localparam logic signed [OUT_W-1:0] HALF = OUT_W'(1 << (FRAC_BITS - 1));
    localparam logic [2:0] LAST_CORNER = 3'd5;

    back_state_t state_reg, state_next;
    job_t job_reg, job_next;
    logic [RKW-1:0] rk0_reg, rk0_next, rk1_reg, rk1_next;
    logic [3:0] mul_idx_reg, mul_idx_next, sel_reg, sel_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [4:0] step_reg, step_next;
    // Cap quotients: cosine lanes and sine lanes, indexed {k1, angle B}.
    logic [QW-1:0] cq_reg [4], cq_next [4], sq_reg [4], sq_next [4];
    logic [CNT_W-1:0] cr_reg [4], cr_next [4], sr_reg [4], sr_next [4];
    logic [3:0] cn_reg, cn_next, sn_reg, sn_next;
    // Side heights, upper and lower edge.
    logic [QW-1:0] hq_reg [2], hq_next [2];
    logic [CNT_W-1:0] hr_reg [2], hr_next [2];
    logic [1:0] hn_reg, hn_next;
    // Side positions, indexed by angle B.
    logic signed [OUT_W-1:0] sx_reg [2], sx_next [2], sz_reg [2], sz_next [2];
    face_t face_reg, face_next;
    logic [2:0] corner_reg, corner_next;
    logic out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic signed [OUT_W-1:0] px_next, py_next, pz_next, nx_next, ny_next, nz_next;
    logic [1:0] fk_reg, fk_next;
    logic last_reg, last_next;

    logic signed [TRIG_W-1:0] mul_trig, nrm_c, nrm_s;
    logic [RKW-1:0] mul_op;
    logic signed [PW-1:0] prod_w;
    logic [MW-1:0] pm, cap_sum, side_sum;
    logic signed [DW-1:0] dh, dn;
    logic [CNT_W-1:0] ah, an;
    logic [HW:0] th, tn;
    logic top_c, right_c, use_b, load;
    logic [1:0] li;

    function automatic logic signed [TRIG_W-1:0] trig_sel(input job_t j, input logic [1:0] s);
        logic signed [TRIG_W-1:0] v;
        begin
            case (s)
                2'd0:    v = j.ca;
                2'd1:    v = j.sa;
                2'd2:    v = j.cb;
                default: v = j.sb;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic [QW-1:0] q, input logic neg);
        logic signed [OUT_W-1:0] v;
        begin
            if (neg)
            begin
                v = (q > QW'(32768)) ? 16'sh8000 : -$signed(q[OUT_W-1:0]);
            end
            else
            begin
                v = (q > QW'(32767)) ? 16'sh7FFF : $signed(q[OUT_W-1:0]);
            end
            return v;
        end
    endfunction

    function automatic logic [CNT_W+QW-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                     input logic [QW-1:0] q,
                                                     input logic [CNT_W-1:0] d);
        logic [CNT_W:0] r, rs;
        logic ge;
        begin
            r  = {rem, q[QW-1]};
            rs = r - {1'b0, d};
            ge = r >= {1'b0, d};
            return {ge ? rs[CNT_W-1:0] : r[CNT_W-1:0], q[QW-2:0], ge};
        end
    endfunction

    // Side normal: round the 2^30-scaled trig value to Q2.14.
    function automatic logic signed [OUT_W-1:0] nrm(input logic signed [TRIG_W-1:0] c);
        logic [TRIG_W:0] m, s;
        begin
            m = c[TRIG_W-1] ? -{c[TRIG_W-1], c} : {1'b0, c};
            s = m + (TRIG_W+1)'(1 << (SH - FRAC_BITS - 1));
            return sat16(QW'(s[TRIG_W:SH-FRAC_BITS]), c[TRIG_W-1]);
        end
    endfunction

    assign empty       = !out_valid_reg;
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign pos_z       = pz_reg;
    assign norm_x      = nx_reg;
    assign norm_y      = ny_reg;
    assign norm_z      = nz_reg;
    assign face_kind   = fk_reg;
    assign last_vertex = last_reg;

    assign mul_trig = trig_sel(job_reg, mul_idx_reg[1:0]);
    assign mul_op   = mul_idx_reg[3] ? RKW'(radius) : (mul_idx_reg[2] ? rk1_reg : rk0_reg);
    assign prod_w   = mul_trig * $signed({1'b0, mul_op});
    assign pm       = prod_reg[PW-1] ? MW'(-prod_reg) : prod_reg[MW-1:0];
    assign cap_sum  = pm + {(MW-CNT_W-SH+1)'(0), rings, (SH-1)'(0)};
    assign side_sum = pm + MW'(1 << (SH - 1));

    always_comb
    begin
        dh = DW'(rings) - DW'({job_reg.ring, 1'b0});
        dn = dh - DW'(2);
        ah = dh[DW-1] ? CNT_W'(-dh) : dh[CNT_W-1:0];
        an = dn[DW-1] ? CNT_W'(-dn) : dn[CNT_W-1:0];
        th = ({1'b0, ah, FRAC_BITS'(0)} + (HW+1)'(rings)) >> 1;
        tn = ({1'b0, an, FRAC_BITS'(0)} + (HW+1)'(rings)) >> 1;

        top_c   = corner_reg == 3'd0 || corner_reg == 3'd4 || corner_reg == 3'd5;
        right_c = corner_reg == 3'd2 || corner_reg == 3'd3 || corner_reg == 3'd4;
        use_b   = (face_reg == FACE_BOTTOM) ? right_c : !right_c;
        li      = {!top_c, use_b};
        nrm_c   = trig_sel(job_reg, {use_b, 1'b0});
        nrm_s   = trig_sel(job_reg, {use_b, 1'b1});

        state_next   = state_reg;
        job_next     = job_reg;
        rk0_next     = rk0_reg;
        rk1_next     = rk1_reg;
        mul_idx_next = mul_idx_reg;
        sel_next     = sel_reg;
        prod_next    = prod_reg;
        step_next    = step_reg;
        cq_next = cq_reg; sq_next = sq_reg; cr_next = cr_reg; sr_next = sr_reg;
        cn_next = cn_reg; sn_next = sn_reg;
        hq_next = hq_reg; hr_next = hr_reg; hn_next = hn_reg;
        sx_next = sx_reg; sz_next = sz_reg;
        face_next   = face_reg;
        corner_next = corner_reg;
        job_pop     = 1'b0;
        load        = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    job_next   = job_in;
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                rk0_next = RKW'(radius) * RKW'(job_reg.ring);
                rk1_next = RKW'(radius) * (RKW'(job_reg.ring) + RKW'(1));
                for (int l = 0; l < 4; l++)
                begin
                    cr_next[l] = '0;
                    sr_next[l] = '0;
                end
                hq_next[0] = QW'(th[HW-1:0]);
                hq_next[1] = QW'(tn[HW-1:0]);
                hr_next[0] = '0;
                hr_next[1] = '0;
                hn_next    = {dn[DW-1], dh[DW-1]};
                mul_idx_next = '0;
                state_next   = B_MUL;
            end
            B_MUL:
            begin
                if (mul_idx_reg != 4'(MUL_COUNT))
                begin
                    prod_next = prod_w;
                    sel_next  = mul_idx_reg;
                end
                if (mul_idx_reg != 4'd0)
                begin
                    if (!sel_reg[3])
                    begin
                        if (sel_reg[0])
                        begin
                            sq_next[{sel_reg[2], sel_reg[1]}] = cap_sum[MW-1:SH];
                            sn_next[{sel_reg[2], sel_reg[1]}] = prod_reg[PW-1];
                        end
                        else
                        begin
                            cq_next[{sel_reg[2], sel_reg[1]}] = cap_sum[MW-1:SH];
                            cn_next[{sel_reg[2], sel_reg[1]}] = prod_reg[PW-1];
                        end
                    end
                    else if (sel_reg[0])
                    begin
                        sz_next[sel_reg[1]] = sat16(side_sum[MW-1:SH], prod_reg[PW-1]);
                    end
                    else
                    begin
                        sx_next[sel_reg[1]] = sat16(side_sum[MW-1:SH], prod_reg[PW-1]);
                    end
                end
                mul_idx_next = mul_idx_reg + 4'd1;
                if (mul_idx_reg == 4'(MUL_COUNT))
                begin
                    step_next  = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    {cr_next[l], cq_next[l]} = div_step(cr_reg[l], cq_reg[l], rings);
                    {sr_next[l], sq_next[l]} = div_step(sr_reg[l], sq_reg[l], rings);
                end
                for (int l = 0; l < 2; l++)
                begin
                    {hr_next[l], hq_next[l]} = div_step(hr_reg[l], hq_reg[l], rings);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    face_next   = FACE_TOP;
                    corner_next = '0;
                    state_next  = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load = 1'b1;
                    if (corner_reg == LAST_CORNER)
                    begin
                        corner_next = '0;
                        if (face_reg == FACE_SIDE)
                        begin
                            state_next = B_IDLE;
                        end
                        else
                        begin
                            face_next = face_t'(face_reg + 2'd1);
                        end
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (face_reg == FACE_SIDE)
        begin
            px_next = sx_reg[use_b];
            pz_next = sz_reg[use_b];
            py_next = sat16(hq_reg[!top_c], hn_reg[!top_c]);
            nx_next = nrm(nrm_c);
            ny_next = '0;
            nz_next = nrm(nrm_s);
        end
        else
        begin
            px_next = sat16(cq_reg[li], cn_reg[li]);
            pz_next = sat16(sq_reg[li], sn_reg[li]);
            py_next = (face_reg == FACE_TOP) ? HALF : -HALF;
            nx_next = '0;
            ny_next = (face_reg == FACE_TOP) ? ONE : -ONE;
            nz_next = '0;
        end
        fk_next   = face_reg;
        last_next = face_reg == FACE_SIDE && corner_reg == LAST_CORNER;

        out_valid_next = out_valid_reg && !pop;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        rk0_reg     <= rk0_next;
        rk1_reg     <= rk1_next;
        mul_idx_reg <= mul_idx_next;
        sel_reg     <= sel_next;
        prod_reg    <= prod_next;
        step_reg    <= step_next;
        cq_reg <= cq_next; sq_reg <= sq_next; cr_reg <= cr_next; sr_reg <= sr_next;
        cn_reg <= cn_next; sn_reg <= sn_next;
        hq_reg <= hq_next; hr_reg <= hr_next; hn_reg <= hn_next;
        sx_reg <= sx_next; sz_reg <= sz_next;
        face_reg    <= face_next;
        corner_reg  <= corner_next;
        if (load)
        begin
            px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next;
            nx_reg <= nx_next; ny_reg <= ny_next; nz_reg <= nz_next;
            fk_reg   <= fk_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/core/cylinder_mesh_tessellator_core.sv =====
`timescale 1ns / 1ps

// Cylinder mesh tessellator. Each input word names a (wedge, ring) pair of a
// unit-height cylinder on the y axis and produces 18 vertex words: six for the
// top-cap tile, six for the bottom-cap tile and six for the side tile, each
// tile as two triangles in the corner order TL, BL, BR, BR, TR, TL. All
// numbers are signed Q2.14. A pair whose wedge or ring index is not below its
// count produces no words. The front part holds one waiting word in an input
// register, turns the wedge edges into turn phases with a bit-serial divider
// and rotates both edges at once with a 30-step CORDIC; that CORDIC and the
// divider set the sustained rate. A two-entry job queue decouples it from the
// back part, which computes the scaling products and a 25-step division by
// the ring count, then delivers one vertex per cycle through an output
// register while pop is held high. Counts above 256 act as 256, and every
// result saturates to 16 bits. Configuration must only be written while the
// block is idle.
module cylinder_mesh_tessellator_core
    import cmt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [RAD_W-1:0]        cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [IDX_W-1:0]        wedge_index,
    input  logic [IDX_W-1:0]        ring_index,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] pos_x,
    output logic signed [OUT_W-1:0] pos_y,
    output logic signed [OUT_W-1:0] pos_z,
    output logic signed [OUT_W-1:0] norm_x,
    output logic signed [OUT_W-1:0] norm_y,
    output logic signed [OUT_W-1:0] norm_z,
    output logic [1:0]              face_kind,
    output logic                    last_vertex
);

    logic [CNT_W-1:0] ring_count_reg, ring_count_next;
    logic [CNT_W-1:0] wedge_count_reg, wedge_count_next;
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [CNT_W-1:0] rings_eff, wedges_eff;

    job_t front_job, queue_job;
    logic job_push, job_full, job_pop, job_empty;

    // Register writes; an unknown index is ignored.
    always_comb
    begin
        ring_count_next  = ring_count_reg;
        wedge_count_next = wedge_count_reg;
        radius_next      = radius_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RING_COUNT:  ring_count_next  = cfg_data[CNT_W-1:0];
                CFG_WEDGE_COUNT: wedge_count_next = cfg_data[CNT_W-1:0];
                CFG_RADIUS:      radius_next      = cfg_data;
                default:         radius_next      = radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg  <= CNT_W'(1);
            wedge_count_reg <= CNT_W'(8);
            radius_reg      <= RAD_W'(8192);
        end
        else
        begin
            ring_count_reg  <= ring_count_next;
            wedge_count_reg <= wedge_count_next;
            radius_reg      <= radius_next;
        end
    end

    // Counts beyond the supported maximum behave as the maximum.
    assign rings_eff  = (ring_count_reg > CNT_W'(MAX_RINGS)) ? CNT_W'(MAX_RINGS)
                                                              : ring_count_reg;
    assign wedges_eff = (wedge_count_reg > CNT_W'(MAX_WEDGES)) ? CNT_W'(MAX_WEDGES)
                                                                : wedge_count_reg;

    cmt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .wedge_index (wedge_index),
        .ring_index  (ring_index),
        .full        (full),
        .wedges      (wedges_eff),
        .rings       (rings_eff),
        .job         (front_job),
        .job_push    (job_push),
        .job_full    (job_full)
    );

    cmt_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (queue_job),
        .empty   (job_empty)
    );

    cmt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_in      (queue_job),
        .job_empty   (job_empty),
        .job_pop     (job_pop),
        .rings       (rings_eff),
        .radius      (radius_reg),
        .empty       (empty),
        .pop         (pop),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .face_kind   (face_kind),
        .last_vertex (last_vertex)
    );

    // The front part only hands over a job when the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
        else $error("job handed to a full queue");

    // The back part only takes a job that is there.
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !job_empty)
        else $error("job taken from an empty queue");

    // An accepted word occupies the input register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> full)
        else $error("accepted word not held");

    // The closing vertex of an item always belongs to the side tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_vertex) |-> face_kind == FACE_SIDE)
        else $error("last vertex outside the side tile");

endmodule
